### hdl/dwc_pkg.sv
package dwc_pkg;

  localparam int MEM_WORDS = 10000;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int NUM_REGS  = 8;
  localparam int REG_AW    = $clog2(NUM_REGS);
  localparam int MAX_WORD  = 999999;
  localparam int HALT_UNITS = 12;
  // floor(n / 10) = (n * RECIP10) >> 35 for any 32-bit n
  localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;

  // result status
  localparam logic [3:0] ST_OK      = 4'd0;
  localparam logic [3:0] ST_HALT    = 4'd1;
  localparam logic [3:0] ST_BADADDR = 4'd2;
  localparam logic [3:0] ST_BADMODE = 4'd3;
  localparam logic [3:0] ST_BADOP   = 4'd4;
  localparam logic [3:0] ST_BADPC   = 4'd5;
  localparam logic [3:0] ST_BADREG  = 4'd6;
  localparam logic [3:0] ST_OVF     = 4'd7;
  localparam logic [3:0] ST_UNF     = 4'd8;
  localparam logic [3:0] ST_DIVZ    = 4'd9;

  // request kinds
  localparam logic [1:0] K_LOAD  = 2'd0;
  localparam logic [1:0] K_START = 2'd1;
  localparam logic [1:0] K_EXEC  = 2'd2;
  localparam logic [1:0] K_READ  = 2'd3;

  // opcodes
  localparam logic [3:0] OP_HALT = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_SUB  = 4'd2;
  localparam logic [3:0] OP_MUL  = 4'd3;
  localparam logic [3:0] OP_DIV  = 4'd4;
  localparam logic [3:0] OP_MOVE = 4'd5;
  localparam logic [3:0] OP_BR   = 4'd6;
  localparam logic [3:0] OP_BMI  = 4'd7;
  localparam logic [3:0] OP_BPL  = 4'd8;
  localparam logic [3:0] OP_BZ   = 4'd9;
  localparam logic [3:0] OP_PUSH = 4'd10;
  localparam logic [3:0] OP_POP  = 4'd11;
  localparam logic [3:0] OP_SYS  = 4'd12;

  // operand modes
  localparam logic [3:0] MD_REG = 4'd1;
  localparam logic [3:0] MD_DEF = 4'd2;
  localparam logic [3:0] MD_INC = 4'd3;
  localparam logic [3:0] MD_DEC = 4'd4;
  localparam logic [3:0] MD_DIR = 4'd5;
  localparam logic [3:0] MD_IMM = 4'd6;

  typedef enum logic [4:0] {
    U_NONE, U_CLEAR, U_CAPTURE, U_DISPATCH, U_READ2, U_FETCH, U_WORD, U_DIGIT,
    U_CHECK, U_OPA, U_OPD, U_OPM, U_ALU, U_MUL, U_MULS, U_DIVS, U_DIVI, U_DIVF,
    U_PUT, U_JUMP, U_JUMP2, U_PUSH, U_POP, U_POP2
  } uop_t;

  typedef struct packed {
    uop_t uop;
    logic slot;   // 0: first operand, 1: second operand
  } cmd_t;

  typedef struct packed {
    logic       fault;
    logic       clear_last;
    logic       dig_last;
    logic       div_last;
    logic [1:0] kind;
    logic [3:0] op;
    logic [3:0] mode;
    logic       taken;
  } sts_t;

  function automatic logic addr_ok(input logic [31:0] a);
    return !a[31] && (a < 32'(MEM_WORDS));
  endfunction

  function automatic logic [31:0] sat33(input logic [32:0] v);
    if (v[32] != v[31]) return v[32] ? 32'h80000000 : 32'h7FFFFFFF;
    return v[31:0];
  endfunction

  function automatic logic [31:0] sat64(input logic [63:0] v);
    if (v[63:31] != {33{v[63]}}) return v[63] ? 32'h80000000 : 32'h7FFFFFFF;
    return v[31:0];
  endfunction

  function automatic logic [3:0] units(input logic [3:0] op);
    case (op)
      OP_HALT:                        return 4'(HALT_UNITS);
      OP_ADD, OP_SUB:                 return 4'd3;
      OP_MUL, OP_DIV:                 return 4'd6;
      OP_MOVE, OP_BR, OP_PUSH, OP_POP: return 4'd2;
      OP_BMI, OP_BPL, OP_BZ:          return 4'd4;
      default:                        return 4'd0;
    endcase
  endfunction

  function automatic logic [31:0] add_clk(input logic [31:0] c, input logic [3:0] n);
    logic [32:0] s;
    s = 33'(c) + 33'(n);
    return s[32] ? 32'hFFFFFFFF : s[31:0];
  endfunction

endpackage

### hdl/dwc_ram.sv
module dwc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/dwc_dpath.sv
module dwc_dpath (
  input  logic            clk,
  input  logic            rst,
  input  dwc_pkg::cmd_t   cmd,
  input  logic [1:0]      kind,
  input  logic [13:0]     word_address,
  input  logic [31:0]     word_value,
  output dwc_pkg::sts_t   sts,
  output logic [3:0]      status,
  output logic [31:0]     read_value,
  output logic [31:0]     program_counter,
  output logic [13:0]     stack_pointer,
  output logic [31:0]     cycle_count,
  output logic            stopped
);

  localparam int AW = dwc_pkg::MEM_AW;

  logic [1:0]  kind_q;
  logic [13:0] addr_q;
  logic [31:0] val_q;
  logic [31:0] pc;
  logic [AW-1:0] sp;
  logic [31:0] clk_units;
  logic        stop_q;
  logic [31:0] regs [dwc_pkg::NUM_REGS];
  logic [19:0] wq;
  logic [3:0]  dig [4];       // 0: reg2, 1: mode2, 2: reg1, 3: mode1
  logic [1:0]  dcnt;
  logic [AW-1:0] a1;
  logic [31:0] v1, v2, r;
  logic [63:0] prod;
  logic [31:0] dvs, quo, rem;
  logic [4:0]  dstep;
  logic        neg;
  logic [3:0]  status_q;
  logic [31:0] rd_q;
  logic [AW-1:0] clr_cnt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   wdata, rdata;

  logic [3:0]  gsel, msel, op;
  logic [31:0] rv, rv_inc, rv_dec;
  logic        pc_ok, sp_ok, rd_ok, ld_ok, word_bad, taken;
  logic [51:0] dprod;
  logic [19:0] dquo;
  logic [3:0]  dnum;
  logic [32:0] trial;
  logic [32:0] dres;
  logic [3:0]  err;
  logic        fault;

  dwc_ram #(.WIDTH(32), .DEPTH(dwc_pkg::MEM_WORDS)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign gsel  = cmd.slot ? dig[0] : dig[2];
  assign msel  = cmd.slot ? dig[1] : dig[3];
  assign op    = wq[3:0];
  assign rv    = regs[gsel[dwc_pkg::REG_AW-1:0]];
  assign rv_inc = dwc_pkg::sat33({rv[31], rv} + 33'd1);
  assign rv_dec = dwc_pkg::sat33({rv[31], rv} - 33'd1);
  assign pc_ok = dwc_pkg::addr_ok(pc);
  assign sp_ok = (32'(sp) + 32'd1) < 32'(dwc_pkg::MEM_WORDS);
  assign rd_ok = 32'(addr_q) < 32'(dwc_pkg::MEM_WORDS);
  assign ld_ok = rd_ok && ($signed(val_q) <= $signed(32'(dwc_pkg::MAX_WORD)));
  assign word_bad = rdata[31] || (rdata > 32'(dwc_pkg::MAX_WORD));

  // divide by ten through the reciprocal
  assign dprod = 52'(wq) * 52'(dwc_pkg::RECIP10);
  assign dquo  = 20'(dprod >> 35);
  assign dnum  = 4'(wq - dquo * 20'd10);

  assign trial = {rem, quo[31]} - {1'b0, dvs};
  assign dres  = neg ? (33'd0 - {1'b0, quo}) : {1'b0, quo};

  always_comb begin
    case (op)
      dwc_pkg::OP_BMI: taken = v1[31];
      dwc_pkg::OP_BPL: taken = !v1[31] && (v1 != 32'd0);
      dwc_pkg::OP_BZ:  taken = (v1 == 32'd0);
      default:         taken = 1'b1;
    endcase
  end

  // error detection for the current step
  always_comb begin
    err = dwc_pkg::ST_OK;
    case (cmd.uop)
      dwc_pkg::U_DISPATCH: begin
        if (kind_q == dwc_pkg::K_READ && !rd_ok) err = dwc_pkg::ST_BADADDR;
        if (kind_q == dwc_pkg::K_EXEC && stop_q) err = dwc_pkg::ST_HALT;
      end
      dwc_pkg::U_FETCH: if (!pc_ok) err = dwc_pkg::ST_BADPC;
      dwc_pkg::U_WORD:  if (word_bad) err = dwc_pkg::ST_BADOP;
      dwc_pkg::U_CHECK: begin
        if (dig[0] > 4'(dwc_pkg::NUM_REGS - 1) || dig[2] > 4'(dwc_pkg::NUM_REGS - 1)) begin
          err = dwc_pkg::ST_BADREG;
        end else if (dig[1] > dwc_pkg::MD_IMM || dig[3] > dwc_pkg::MD_IMM) begin
          err = dwc_pkg::ST_BADMODE;
        end else if (wq > 20'(dwc_pkg::OP_SYS)) begin
          err = dwc_pkg::ST_BADOP;
        end else if (op == dwc_pkg::OP_HALT) begin
          err = dwc_pkg::ST_HALT;
        end
      end
      dwc_pkg::U_OPA: begin
        case (msel)
          dwc_pkg::MD_REG: err = dwc_pkg::ST_OK;
          dwc_pkg::MD_DEF, dwc_pkg::MD_INC:
            if (!dwc_pkg::addr_ok(rv)) err = dwc_pkg::ST_BADADDR;
          dwc_pkg::MD_DEC:
            if (!dwc_pkg::addr_ok(rv_dec)) err = dwc_pkg::ST_BADADDR;
          dwc_pkg::MD_DIR, dwc_pkg::MD_IMM:
            if (!pc_ok) err = dwc_pkg::ST_BADPC;
          default: err = dwc_pkg::ST_BADMODE;
        endcase
      end
      dwc_pkg::U_OPD:  if (!dwc_pkg::addr_ok(rdata)) err = dwc_pkg::ST_BADADDR;
      dwc_pkg::U_DIVS: if (v2 == 32'd0) err = dwc_pkg::ST_DIVZ;
      dwc_pkg::U_PUT:  if (dig[3] == dwc_pkg::MD_IMM) err = dwc_pkg::ST_BADMODE;
      dwc_pkg::U_JUMP: if (taken && !pc_ok) err = dwc_pkg::ST_BADPC;
      dwc_pkg::U_PUSH: if (!sp_ok) err = dwc_pkg::ST_OVF;
      dwc_pkg::U_POP:  if (sp == '0) err = dwc_pkg::ST_UNF;
      default: err = dwc_pkg::ST_OK;
    endcase
  end
  assign fault = (err != dwc_pkg::ST_OK);

  // memory ports
  always_comb begin
    we    = 1'b0;
    waddr = clr_cnt;
    wdata = '0;
    raddr = pc[AW-1:0];
    case (cmd.uop)
      dwc_pkg::U_CLEAR: we = 1'b1;
      dwc_pkg::U_DISPATCH: begin
        raddr = addr_q[AW-1:0];
        if (kind_q == dwc_pkg::K_LOAD && ld_ok) begin
          we    = 1'b1;
          waddr = addr_q[AW-1:0];
          wdata = val_q;
        end
      end
      dwc_pkg::U_OPA: begin
        if (msel == dwc_pkg::MD_DEC) raddr = rv_dec[AW-1:0];
        else if (msel == dwc_pkg::MD_DEF || msel == dwc_pkg::MD_INC) raddr = rv[AW-1:0];
      end
      dwc_pkg::U_OPD: raddr = rdata[AW-1:0];
      dwc_pkg::U_POP: raddr = sp;
      dwc_pkg::U_PUT: begin
        waddr = a1;
        wdata = r;
        we    = !fault && (dig[3] != dwc_pkg::MD_REG);
      end
      dwc_pkg::U_PUSH: begin
        waddr = sp + AW'(1);
        wdata = v1;
        we    = !fault;
      end
      default: raddr = pc[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      sp        <= '0;
      clk_units <= '0;
      stop_q    <= 1'b1;
      clr_cnt   <= '0;
      status_q  <= dwc_pkg::ST_OK;
      rd_q      <= '0;
      for (int i = 0; i < dwc_pkg::NUM_REGS; i++) regs[i] <= '0;
    end else begin
      case (cmd.uop)
        dwc_pkg::U_CLEAR: clr_cnt <= clr_cnt + AW'(1);
        dwc_pkg::U_CAPTURE: begin
          kind_q <= kind;
          addr_q <= word_address;
          val_q  <= word_value;
        end
        dwc_pkg::U_DISPATCH: begin
          rd_q <= '0;
          case (kind_q)
            dwc_pkg::K_LOAD: status_q <= ld_ok ? dwc_pkg::ST_OK : dwc_pkg::ST_BADADDR;
            dwc_pkg::K_START: begin
              if (!dwc_pkg::addr_ok(val_q)) begin
                status_q <= dwc_pkg::ST_BADPC;
                stop_q   <= 1'b1;
              end else begin
                status_q  <= dwc_pkg::ST_OK;
                pc        <= val_q;
                clk_units <= '0;
                stop_q    <= 1'b0;
              end
            end
            default: status_q <= err;
          endcase
        end
        dwc_pkg::U_READ2: rd_q <= rdata;
        dwc_pkg::U_FETCH: if (!fault) pc <= pc + 32'd1;
        dwc_pkg::U_WORD: begin
          wq   <= rdata[19:0];
          dcnt <= '0;
        end
        dwc_pkg::U_DIGIT: begin
          for (int i = 0; i < 3; i++) dig[i] <= dig[i+1];
          dig[3] <= dnum;
          wq     <= dquo;
          dcnt   <= dcnt + 2'd1;
        end
        dwc_pkg::U_CHECK:
          if (err == dwc_pkg::ST_HALT) clk_units <= dwc_pkg::add_clk(clk_units, dwc_pkg::units(op));
        dwc_pkg::U_OPA: begin
          if (!cmd.slot) a1 <= (msel == dwc_pkg::MD_DEC) ? rv_dec[AW-1:0] : rv[AW-1:0];
          case (msel)
            dwc_pkg::MD_REG: if (!cmd.slot) v1 <= rv; else v2 <= rv;
            dwc_pkg::MD_INC: if (!fault) regs[gsel[dwc_pkg::REG_AW-1:0]] <= rv_inc;
            dwc_pkg::MD_DEC: regs[gsel[dwc_pkg::REG_AW-1:0]] <= rv_dec;
            dwc_pkg::MD_DIR, dwc_pkg::MD_IMM: if (!fault) pc <= pc + 32'd1;
            default: ;
          endcase
        end
        dwc_pkg::U_OPD: if (!cmd.slot) a1 <= rdata[AW-1:0];
        dwc_pkg::U_OPM: if (!cmd.slot) v1 <= rdata; else v2 <= rdata;
        dwc_pkg::U_ALU: begin
          case (op)
            dwc_pkg::OP_ADD: r <= dwc_pkg::sat33({v1[31], v1} + {v2[31], v2});
            dwc_pkg::OP_SUB: r <= dwc_pkg::sat33({v1[31], v1} - {v2[31], v2});
            default:         r <= v2;
          endcase
        end
        dwc_pkg::U_MUL:  prod <= 64'($signed(v1)) * 64'($signed(v2));
        dwc_pkg::U_MULS: r <= dwc_pkg::sat64(prod);
        dwc_pkg::U_DIVS: begin
          quo   <= v1[31] ? 32'd0 - v1 : v1;
          dvs   <= v2[31] ? 32'd0 - v2 : v2;
          rem   <= '0;
          neg   <= v1[31] ^ v2[31];
          dstep <= '0;
        end
        dwc_pkg::U_DIVI: begin
          if (!trial[32]) begin
            rem <= trial[31:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem <= {rem[30:0], quo[31]};
            quo <= {quo[30:0], 1'b0};
          end
          dstep <= dstep + 5'd1;
        end
        dwc_pkg::U_DIVF: r <= dwc_pkg::sat33(dres);
        dwc_pkg::U_PUT: begin
          if (!fault) begin
            if (dig[3] == dwc_pkg::MD_REG) regs[dig[2][dwc_pkg::REG_AW-1:0]] <= r;
            clk_units <= dwc_pkg::add_clk(clk_units, dwc_pkg::units(op));
          end
        end
        dwc_pkg::U_JUMP: begin
          if (!taken) begin
            pc        <= pc + 32'd1;
            clk_units <= dwc_pkg::add_clk(clk_units, dwc_pkg::units(op));
          end
        end
        dwc_pkg::U_JUMP2: begin
          pc        <= rdata;
          clk_units <= dwc_pkg::add_clk(clk_units, dwc_pkg::units(op));
        end
        dwc_pkg::U_PUSH: begin
          if (!fault) begin
            sp        <= sp + AW'(1);
            clk_units <= dwc_pkg::add_clk(clk_units, dwc_pkg::units(op));
          end
        end
        dwc_pkg::U_POP2: begin
          r  <= rdata;
          sp <= sp - AW'(1);
        end
        default: ;
      endcase
      // execution faults end the instruction and stop the core
      if (fault && cmd.uop != dwc_pkg::U_DISPATCH) begin
        status_q <= err;
        stop_q   <= 1'b1;
      end
    end
  end

  assign sts.fault      = fault;
  assign sts.clear_last = (clr_cnt == AW'(dwc_pkg::MEM_WORDS - 1));
  assign sts.dig_last   = (dcnt == 2'd3);
  assign sts.div_last   = (dstep == 5'd31);
  assign sts.kind       = kind_q;
  assign sts.op         = op;
  assign sts.mode       = msel;
  assign sts.taken      = taken;

  assign status          = status_q;
  assign read_value      = rd_q;
  assign program_counter = pc;
  assign stack_pointer   = 14'(sp);
  assign cycle_count     = clk_units;
  assign stopped         = stop_q;

endmodule

### hdl/dwc_ctrl.sv
module dwc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  dwc_pkg::sts_t sts,
  output dwc_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done
);

  typedef enum logic [23:0] {
    S_CLEAR = 24'h000001, S_IDLE  = 24'h000002, S_DISP  = 24'h000004,
    S_READ2 = 24'h000008, S_FETCH = 24'h000010, S_WORD  = 24'h000020,
    S_DIGIT = 24'h000040, S_CHECK = 24'h000080, S_OPA   = 24'h000100,
    S_OPD   = 24'h000200, S_OPM   = 24'h000400, S_ALU   = 24'h000800,
    S_MUL   = 24'h001000, S_MULS  = 24'h002000, S_DIVS  = 24'h004000,
    S_DIVI  = 24'h008000, S_DIVF  = 24'h010000, S_PUT   = 24'h020000,
    S_JUMP  = 24'h040000, S_JUMP2 = 24'h080000, S_PUSH  = 24'h100000,
    S_POP   = 24'h200000, S_POP2  = 24'h400000, S_DONE  = 24'h800000
  } state_t;

  state_t state, state_next, after_opnd;
  logic   slot, slot_next;

  // where to go once an operand is in hand
  always_comb begin
    after_opnd = S_DONE;
    if (slot) begin
      case (sts.op)
        dwc_pkg::OP_MUL: after_opnd = S_MUL;
        dwc_pkg::OP_DIV: after_opnd = S_DIVS;
        default:         after_opnd = S_ALU;
      endcase
    end else begin
      case (sts.op)
        dwc_pkg::OP_ADD, dwc_pkg::OP_SUB, dwc_pkg::OP_MUL,
        dwc_pkg::OP_DIV, dwc_pkg::OP_MOVE:                   after_opnd = S_OPA;
        dwc_pkg::OP_BMI, dwc_pkg::OP_BPL, dwc_pkg::OP_BZ:   after_opnd = S_JUMP;
        dwc_pkg::OP_PUSH:                                    after_opnd = S_PUSH;
        dwc_pkg::OP_POP:                                     after_opnd = S_POP;
        default:                                             after_opnd = S_DONE;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    slot_next  = slot;
    cmd.uop    = dwc_pkg::U_NONE;
    case (state)
      S_CLEAR: begin
        cmd.uop = dwc_pkg::U_CLEAR;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.uop    = dwc_pkg::U_CAPTURE;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        cmd.uop = dwc_pkg::U_DISPATCH;
        if (sts.fault) state_next = S_DONE;
        else if (sts.kind == dwc_pkg::K_READ) state_next = S_READ2;
        else if (sts.kind == dwc_pkg::K_EXEC) state_next = S_FETCH;
        else state_next = S_DONE;
      end
      S_READ2: begin
        cmd.uop    = dwc_pkg::U_READ2;
        state_next = S_DONE;
      end
      S_FETCH: begin
        cmd.uop    = dwc_pkg::U_FETCH;
        state_next = sts.fault ? S_DONE : S_WORD;
      end
      S_WORD: begin
        cmd.uop    = dwc_pkg::U_WORD;
        state_next = sts.fault ? S_DONE : S_DIGIT;
      end
      S_DIGIT: begin
        cmd.uop = dwc_pkg::U_DIGIT;
        if (sts.dig_last) state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.uop   = dwc_pkg::U_CHECK;
        slot_next = 1'b0;
        if (sts.fault) state_next = S_DONE;
        else if (sts.op == dwc_pkg::OP_BR) state_next = S_JUMP;
        else state_next = S_OPA;
      end
      S_OPA: begin
        cmd.uop = dwc_pkg::U_OPA;
        if (sts.fault) state_next = S_DONE;
        else if (sts.mode == dwc_pkg::MD_REG) begin
          state_next = after_opnd;
          slot_next  = 1'b1;
        end else if (sts.mode == dwc_pkg::MD_DIR) state_next = S_OPD;
        else state_next = S_OPM;
      end
      S_OPD: begin
        cmd.uop    = dwc_pkg::U_OPD;
        state_next = sts.fault ? S_DONE : S_OPM;
      end
      S_OPM: begin
        cmd.uop    = dwc_pkg::U_OPM;
        state_next = after_opnd;
        slot_next  = 1'b1;
      end
      S_ALU: begin
        cmd.uop    = dwc_pkg::U_ALU;
        state_next = S_PUT;
      end
      S_MUL: begin
        cmd.uop    = dwc_pkg::U_MUL;
        state_next = S_MULS;
      end
      S_MULS: begin
        cmd.uop    = dwc_pkg::U_MULS;
        state_next = S_PUT;
      end
      S_DIVS: begin
        cmd.uop    = dwc_pkg::U_DIVS;
        state_next = sts.fault ? S_DONE : S_DIVI;
      end
      S_DIVI: begin
        cmd.uop = dwc_pkg::U_DIVI;
        if (sts.div_last) state_next = S_DIVF;
      end
      S_DIVF: begin
        cmd.uop    = dwc_pkg::U_DIVF;
        state_next = S_PUT;
      end
      S_PUT: begin
        cmd.uop    = dwc_pkg::U_PUT;
        slot_next  = 1'b0;
        state_next = S_DONE;
      end
      S_JUMP: begin
        cmd.uop = dwc_pkg::U_JUMP;
        state_next = (!sts.fault && sts.taken) ? S_JUMP2 : S_DONE;
      end
      S_JUMP2: begin
        cmd.uop    = dwc_pkg::U_JUMP2;
        state_next = S_DONE;
      end
      S_PUSH: begin
        cmd.uop    = dwc_pkg::U_PUSH;
        state_next = S_DONE;
      end
      S_POP: begin
        cmd.uop    = dwc_pkg::U_POP;
        state_next = sts.fault ? S_DONE : S_POP2;
      end
      S_POP2: begin
        cmd.uop    = dwc_pkg::U_POP2;
        slot_next  = 1'b0;
        state_next = S_PUT;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    // PUT always works on the first operand
    cmd.slot = (state == S_PUT) ? 1'b0 : slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      slot  <= 1'b0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

### hdl/decimal_word_cpu_step.sv
// Request flow: load, start and refused requests end after dispatch, a read after a
//   further memory read step; an instruction runs through its micro-steps unless a fault
//   ends it sooner, the longest a divide with two direct operands (serial divider).
// Throughput: one request at a time; busy stays high until the done cycle ends.
// Reset: synchronous rst; afterwards a clearing pass zeroes the 10000-word memory
//   at one word a cycle with busy high. The receiver cannot stall.
module decimal_word_cpu_step (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [13:0] word_address,
  input  logic [31:0] word_value,
  output logic        done,
  output logic [3:0]  status,
  output logic [31:0] read_value,
  output logic [31:0] program_counter,
  output logic [13:0] stack_pointer,
  output logic [31:0] cycle_count,
  output logic        stopped
);

  // The controller walks one micro-step per cycle: dispatch on the request kind,
  // fetch, split the word into decimal digits (one divide-by-ten a cycle),
  // check, gather operands, run the ALU / multiplier / divider, write back or branch / push / pop.
  // The datapath reports errors for the step in flight; any error ends the
  // request early; the datapath latches the code, and past dispatch also sets stopped.
  dwc_pkg::cmd_t cmd;
  dwc_pkg::sts_t sts;

  dwc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Holds main memory, the eight registers, pc, sp, clock count and the
  // result registers; outputs come straight from those registers.
  dwc_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .kind            (kind),
    .word_address    (word_address),
    .word_value      (word_value),
    .sts             (sts),
    .status          (status),
    .read_value      (read_value),
    .program_counter (program_counter),
    .stack_pointer   (stack_pointer),
    .cycle_count     (cycle_count),
    .stopped         (stopped)
  );

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done strobe outside a request");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");
  a_fault_stops: assert property (@(posedge clk) disable iff (rst)
      (done && (status == dwc_pkg::ST_DIVZ || status == dwc_pkg::ST_BADOP ||
                status == dwc_pkg::ST_UNF)) |-> stopped)
    else $error("execution fault without stopped");
`endif

endmodule
